// ===== rtl/itgdt_pkg.sv =====
// shared types, constants and helper functions for the grouped decimal text unit
// no dependencies; imported by every module of the block
`default_nettype none

package itgdt_pkg;

    localparam int VALUE_W    = 64;                 // width of the signed input value
    localparam int NUM_DIGITS = 20;                 // bcd digits, enough for 2^63
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int BITS_PER_STEP = 2;               // binary bits absorbed per cycle
    localparam int CONV_STEPS = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W = $clog2(CONV_STEPS);
    localparam int CHAR_W     = 7;
    localparam int TDATA_W    = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 7'h2C;  // ','
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;  // '-'

    typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

    // finished conversion passed from the converter to the emitter
    typedef struct packed {
        logic negative;
        bcd_t digits;
    } conv_result_t;

    // position of the leading digit and that position modulo 3
    typedef struct packed {
        logic [DIGIT_IDX_W-1:0] idx;
        logic [1:0]             mod3;
    } lead_t;

    // one double-dabble step: adjust every digit, then shift in one bit
    // the top bit shifted out is always zero since the magnitude is below 10^20
    function automatic bcd_t dabble_step(input bcd_t bcd, input logic bit_in);
        bcd_t                    adj;
        logic [NUM_DIGITS*4-1:0] flat;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
        end
        flat = adj;
        return {flat[NUM_DIGITS*4-2:0], bit_in};
    endfunction

    // highest nonzero digit, zero when the whole number is zero
    function automatic lead_t find_lead(input bcd_t bcd);
        lead_t      res;
        logic [1:0] m;
        res = '0;
        m   = 2'd0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i] != 4'd0) begin
                res.idx  = DIGIT_IDX_W'(i);
                res.mod3 = m;
            end
            m = (m == 2'd2) ? 2'd0 : m + 2'd1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/itgdt_bcd_conv.sv =====
// binary to bcd converter, double dabble taking two bits per cycle
// depends on itgdt_pkg
`default_nettype none

module itgdt_bcd_conv (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [itgdt_pkg::VALUE_W-1:0] in_value,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output itgdt_pkg::conv_result_t           res
);
    import itgdt_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VALUE_W-1:0]    bin_reg, bin_next;
    bcd_t                  bcd_reg, bcd_next;
    logic                  neg_reg, neg_next;
    bcd_t                  bcd_mid;

    assign in_ready  = !busy_reg && !done_reg;
    assign res_valid = done_reg;
    assign res.negative = neg_reg;
    assign res.digits   = bcd_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        // absorb the top bits of the magnitude, most significant first
        bcd_mid   = bcd_reg;
        for (int b = 0; b < BITS_PER_STEP; b++) begin
            bcd_mid = dabble_step(bcd_mid, bin_reg[VALUE_W-1-b]);
        end
        if (in_valid && in_ready) begin
            // magnitude in unsigned arithmetic, exact for the most negative value
            neg_next  = in_value[VALUE_W-1];
            bin_next  = in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = bcd_mid;
            bin_next = bin_reg << BITS_PER_STEP;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_CNT_W'(CONV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (done_reg && res_ready) begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

endmodule

`default_nettype wire

// ===== rtl/itgdt_char_emit.sv =====
// character sequencer: sign, digits and group commas, one per cycle while out_ready is high
// depends on itgdt_pkg
`default_nettype none

module itgdt_char_emit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         res_valid,
    output logic                              res_ready,
    input  wire itgdt_pkg::conv_result_t      res,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [itgdt_pkg::CHAR_W-1:0]      out_char,
    output logic                              out_last
);
    import itgdt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SIGN  = 2'd1;
    localparam logic [1:0] ST_DIGIT = 2'd2;
    localparam logic [1:0] ST_COMMA = 2'd3;

    logic [1:0]             st_reg, st_next;
    logic [DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]             m3_reg, m3_next;
    bcd_t                   bcd_reg, bcd_next;
    logic                   vld_reg, vld_next;
    logic [CHAR_W-1:0]      chr_reg, chr_next;
    logic                   last_reg, last_next;
    logic                   slot_free;
    lead_t                  lead;

    assign res_ready = (st_reg == ST_IDLE);
    assign slot_free = !vld_reg || out_ready;
    assign lead      = find_lead(res.digits);
    assign out_valid = vld_reg;
    assign out_char  = chr_reg;
    assign out_last  = last_reg;

    always_comb begin
        st_next   = st_reg;
        idx_next  = idx_reg;
        m3_next   = m3_reg;
        bcd_next  = bcd_reg;
        vld_next  = vld_reg && !out_ready;
        chr_next  = chr_reg;
        last_next = last_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (res_valid) begin
                    bcd_next = res.digits;
                    idx_next = lead.idx;
                    m3_next  = lead.mod3;
                    st_next  = res.negative ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    vld_next  = 1'b1;
                    chr_next  = CHAR_MINUS;
                    last_next = 1'b0;
                    st_next   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (slot_free) begin
                    vld_next  = 1'b1;
                    chr_next  = CHAR_ZERO + {3'b000, bcd_reg[idx_reg]};
                    last_next = (idx_reg == '0);
                    idx_next  = idx_reg - 1'b1;
                    m3_next   = (m3_reg == 2'd0) ? 2'd2 : m3_reg - 2'd1;
                    if (idx_reg == '0) begin
                        st_next = ST_IDLE;
                    end else if (m3_reg == 2'd0) begin
                        st_next = ST_COMMA;
                    end
                end
            end
            ST_COMMA: begin
                if (slot_free) begin
                    vld_next  = 1'b1;
                    chr_next  = CHAR_COMMA;
                    last_next = 1'b0;
                    st_next   = ST_DIGIT;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_IDLE;
            vld_reg <= 1'b0;
        end else begin
            st_reg  <= st_next;
            vld_reg <= vld_next;
        end
        idx_reg  <= idx_next;
        m3_reg   <= m3_next;
        bcd_reg  <= bcd_next;
        chr_reg  <= chr_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

// ===== rtl/int_to_grouped_decimal_text_unit.sv =====
// an accepted value runs through all converter steps and is held as the done result until the
// emitter takes it while idle; the emitter then registers the first character and raises m_tvalid
// the double-dabble converter takes two bits per cycle and no new value while busy or while its
// result waits; the character emitter sends one character per cycle while m_tready is high
// the converter works on the next value while the emitter still sends the previous one
// reset: synchronous, active low aresetn; clears handshake and state, no clearing pass
`default_nettype none

module int_to_grouped_decimal_text_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // slave side: one signed integer per request
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [itgdt_pkg::VALUE_W-1:0] s_tdata,   // [63:0] value
    // master side: one ascii character per request
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [itgdt_pkg::TDATA_W-1:0]     m_tdata,   // [6:0] character, [7] zero
    output logic                              m_tlast    // is_last
);
    import itgdt_pkg::*;

    // handoff between converter and emitter
    conv_result_t      conv_res;
    logic              conv_valid;
    logic              conv_ready;
    logic [CHAR_W-1:0] out_char;

    // binary magnitude into 20 bcd digits, two input bits per cycle
    itgdt_bcd_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .res_valid (conv_valid),
        .res_ready (conv_ready),
        .res       (conv_res)
    );

    // sign, digits from the leading one down, comma before each three-digit group counted from the units digit
    itgdt_char_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (conv_valid),
        .res_ready (conv_ready),
        .res       (conv_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    // character in the low seven bits, padded to a full byte
    assign m_tdata = {{(TDATA_W - CHAR_W){1'b0}}, out_char};

endmodule

`default_nettype wire

// ===== rtl/itgdt_checker.sv =====
// port-level assertions for the grouped decimal text unit, bound to the top level
// depends on itgdt_pkg and int_to_grouped_decimal_text_unit
`default_nettype none

module itgdt_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [itgdt_pkg::TDATA_W-1:0] m_tdata,
    input wire logic                         m_tlast
);
    import itgdt_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // only digits, comma or minus, top bit clear
    a_legal_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7] == 1'b0) &&
            ((m_tdata[6:0] >= CHAR_ZERO && m_tdata[6:0] <= CHAR_ZERO + 7'd9) ||
             m_tdata[6:0] == CHAR_COMMA || m_tdata[6:0] == CHAR_MINUS))
        else $error("illegal character");

    // a run never ends on a separator or a sign
    a_last_is_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[6:0] != CHAR_COMMA && m_tdata[6:0] != CHAR_MINUS)
        else $error("run ends on a non-digit");

    // converter is busy after taking a value
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accepted request");

endmodule

bind int_to_grouped_decimal_text_unit itgdt_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
